// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising clock edge, off during reset
`define ODA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oda assertion failed");

// next-cycle implication on the rising clock edge, off during reset
`define ODA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oda assertion failed");

`endif

// ===== sv/oda_pkg.sv =====
// shared constants and control types of the one-dimensional life automaton
package oda_pkg;

  localparam int WORD_BITS = 64;
  localparam int WORD_SHIFT = 6;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CELLS_IN_USE_RESET = 9'd256;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CELLS_IN_USE = 1'b0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } oda_cmd_t;

  typedef struct packed {
    logic out_free;
    logic word_last;
  } oda_sts_t;

endpackage

// ===== sv/oda_ctrl.sv =====
// controller: sequences loads, generation steps and the word-by-word output
module oda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               cmd_i,
  input  oda_pkg::oda_sts_t  sts_i,
  output logic               in_stall_o,
  output oda_pkg::oda_cmd_t  cmd_o
);
  import oda_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EMIT = 1'b1;

  logic [0:0] state_q, state_d;
  logic       emit;
  logic       ready;
  logic       accept;

  always_comb begin
    emit   = (state_q == ST_EMIT) && sts_i.out_free;
    // the next item may enter together with the final output beat
    ready  = (state_q == ST_IDLE) || (emit && sts_i.word_last);
    accept = in_valid_i && ready;

    cmd_o.load = accept && (cmd_i == CMD_LOAD);
    cmd_o.step = accept && (cmd_i == CMD_STEP);
    cmd_o.emit = emit;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.step) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.step) state_d = ST_EMIT;
        else if (emit && sts_i.word_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/oda_dp.sv =====
// datapath: row, per-cell history, rule logic, word counter and output register
module oda_dp #(
  parameter int CELLS         = 256,
  parameter int HISTORY_DEPTH = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  oda_pkg::oda_cmd_t           cmd_i,
  output oda_pkg::oda_sts_t           sts_o,
  input  logic [oda_pkg::CFG_W-1:0]   cells_in_use_i,
  input  logic [1:0]                  word_index_i,
  input  logic [oda_pkg::WORD_BITS-1:0] seed_cells_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [1:0]                  word_index_res_o,
  output logic [oda_pkg::WORD_BITS-1:0] row_cells_o,
  output logic                        last_o,
  output logic                        settled_o
);
  import oda_pkg::*;

  localparam int RW = (CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW = (RW > 1) ? $clog2(RW) : 1;
  localparam int PW = RW * WORD_BITS;
  localparam int AW = ($clog2(CELLS + 1) > CFG_W) ? $clog2(CELLS + 1) : CFG_W;
  localparam logic [HISTORY_DEPTH-1:0] HIST_ONES = {HISTORY_DEPTH{1'b1}};

  logic [CELLS-1:0]                     pend_q, pend_d;
  logic [CELLS-1:0][HISTORY_DEPTH-1:0]  hist_q, hist_d;
  logic [CELLS-1:0]                     flag_q;
  logic [WW-1:0]                        word_q;
  logic                                 acc_q;

  logic [AW-1:0]                        active;
  logic [WW-1:0]                        last_word;
  logic [CELLS-1:0]                     mask;
  logic [CELLS-1:0]                     cur;
  logic [CELLS+3:0]                     cur_pad;
  logic [CELLS-1:0]                     nxt;
  logic [CELLS-1:0][HISTORY_DEPTH-1:0]  hist_sh;
  logic [CELLS-1:0]                     flag;
  logic [PW-1:0]                        pend_pad;
  logic [PW-1:0]                        flag_pad;
  logic [WORD_BITS-1:0]                 word_row;
  logic                                 word_flag;

  logic                                 out_valid_q;
  logic [1:0]                           out_idx_q;
  logic [WORD_BITS-1:0]                 out_row_q;
  logic                                 out_last_q;
  logic                                 out_settled_q;

  // active width, clipped to the row
  always_comb begin
    if (AW'(cells_in_use_i) > AW'(CELLS)) active = AW'(CELLS);
    else active = AW'(cells_in_use_i);
    if (active == '0) last_word = '0;
    else last_word = WW'((active - AW'(1)) >> WORD_SHIFT);
  end

  // rule evaluation, one cell of logic per cell of the row
  always_comb begin
    logic [2:0] total;
    logic       nv;
    for (int i = 0; i < CELLS; i++) begin
      mask[i] = (AW'(i) < active);
      cur[i]  = pend_q[i] & mask[i];
    end
    cur_pad = {2'b00, cur, 2'b00};
    for (int i = 0; i < CELLS; i++) begin
      total = 3'(cur_pad[i]) + 3'(cur_pad[i+1]) + 3'(cur_pad[i+3]) + 3'(cur_pad[i+4]);
      if (cur_pad[i+2]) nv = (total == 3'd2) || (total == 3'd4);
      else nv = (total == 3'd2) || (total == 3'd3);
      nxt[i]     = nv & mask[i];
      hist_sh[i] = HISTORY_DEPTH'({hist_q[i], cur[i]});
      // next value differs from each of the last HISTORY_DEPTH values of the cell
      flag[i]    = mask[i] & (nxt[i] ? (hist_sh[i] == '0) : (hist_sh[i] == HIST_ONES));
    end
  end

  always_comb begin
    pend_d = pend_q;
    hist_d = hist_q;
    if (cmd_i.step) begin
      pend_d = nxt;
      hist_d = hist_sh;
    end else if (cmd_i.load) begin
      hist_d = '0;
      for (int i = 0; i < CELLS; i++) begin
        if ((i >> WORD_SHIFT) == int'(word_index_i)) begin
          pend_d[i] = seed_cells_i[i % WORD_BITS];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      hist_q <= '0;
    end else begin
      pend_q <= pend_d;
      hist_q <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) flag_q <= flag;
  end

  // word selection for the output beat
  always_comb begin
    pend_pad  = PW'(pend_q);
    flag_pad  = PW'(flag_q);
    word_row  = pend_pad[word_q*WORD_BITS +: WORD_BITS];
    word_flag = |flag_pad[word_q*WORD_BITS +: WORD_BITS];
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.word_last = (word_q == last_word);

  // word counter and running unsettled flag; a new step restarts both
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      acc_q  <= 1'b0;
    end else if (cmd_i.step) begin
      word_q <= '0;
      acc_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      word_q <= word_q + WW'(1);
      acc_q  <= acc_q | word_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q     <= 2'(word_q);
      out_row_q     <= word_row;
      out_last_q    <= sts_o.word_last;
      out_settled_q <= sts_o.word_last & ~(acc_q | word_flag);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign word_index_res_o = out_idx_q;
  assign row_cells_o      = out_row_q;
  assign last_o           = out_last_q;
  assign settled_o        = out_settled_q;

endmodule

// ===== sv/one_d_life_automaton.sv =====
// top level of the radius-two one-dimensional life automaton
//
// input channel (in_valid_i / in_stall_o): one beat is a command. A load
// (cmd_i = 0) writes seed_cells_i into word word_index_i of the pending row
// and clears all cell history; it gives no output. A step (cmd_i = 1)
// makes the pending row current, shifts the history and computes the next
// row, then sends it on the output channel (out_valid_o / out_stall_i) as
// ceil(active/64) beats (one beat at zero width), one per cycle while the
// output is not stalled; the step passes the row register and the emit
// state before the first beat leaves the output word register. last_o
// marks the final beat, which also carries settled_o. The next command,
// also a new step, is taken in the same cycle as the final word of the row
// is written into the output word register. A stalled output holds its
// beat and the word sequencer waits. cells_in_use is written over the APB
// port at address 0, by the user only while idle; the block does not
// enforce this. Reset clears the row and history and sets cells_in_use to 256.
module one_d_life_automaton #(
  parameter int CELLS         = 256,
  parameter int HISTORY_DEPTH = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oda_pkg::PADDR_W-1:0]     paddr,
  input  logic [oda_pkg::PDATA_W-1:0]     pwdata,
  output logic [oda_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [1:0]                      word_index_i,
  input  logic [oda_pkg::WORD_BITS-1:0]   seed_cells_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      word_index_res_o,
  output logic [oda_pkg::WORD_BITS-1:0]   row_cells_o,
  output logic                            last_o,
  output logic                            settled_o
);
  import oda_pkg::*;

  logic [CFG_W-1:0] cells_q;
  logic             cfg_we;
  oda_cmd_t         cmd;
  oda_sts_t         sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= CELLS_IN_USE_RESET;
    end else if (cfg_we && (paddr[2] == REG_CELLS_IN_USE)) begin
      cells_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CELLS_IN_USE) prdata = PDATA_W'(cells_q);
    else prdata = '0;
  end

  oda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  oda_dp #(
    .CELLS         (CELLS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cells_in_use_i   (cells_q),
    .word_index_i     (word_index_i),
    .seed_cells_i     (seed_cells_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .word_index_res_o (word_index_res_o),
    .row_cells_o      (row_cells_o),
    .last_o           (last_o),
    .settled_o        (settled_o)
  );

endmodule

// ===== sv/oda_checker.sv =====
// port-level checks of the life automaton, bound to the top level
`include "assert_macros.svh"

module oda_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            cmd_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [oda_pkg::WORD_BITS-1:0]   row_cells_o,
  input logic                            last_o,
  input logic                            settled_o
);
  import oda_pkg::*;

  // a held output beat keeps its contents
  `ODA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(row_cells_o) && $stable(last_o))

  // settled is only reported on the final beat of a generation
  `ODA_ASSERT_SAME(a_settled_last, out_valid_o && settled_o, last_o)

  // a load never leaves the input stalled after it is taken
  `ODA_ASSERT_NEXT(a_load_free, in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD), !in_stall_o)

  // while an inner beat of a generation is held, no new command enters
  `ODA_ASSERT_SAME(a_busy_mid_row, out_valid_o && !last_o && out_stall_i, in_stall_o)

endmodule

bind one_d_life_automaton oda_checker u_oda_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench of the one-dimensional life automaton
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CELLS = 256;
  localparam int HIST_DEPTH = 7;
  localparam int WB = oda_pkg::WORD_BITS;
  localparam int ADDR_W = oda_pkg::PADDR_W;
  localparam logic [ADDR_W-1:0] CELLS_IN_USE_ADDR =
    ADDR_W'(4 * int'(oda_pkg::REG_CELLS_IN_USE));
  localparam int LONG_HOLD = 120;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic          cmd;
    logic [1:0]    idx;
    logic [WB-1:0] seed;
    bit            drain_first;
  } life_cmd_t;

  typedef struct {
    logic [1:0]    word_index;
    logic [WB-1:0] cells;
    logic          last;
    logic          settled;
  } life_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [oda_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [oda_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i = oda_pkg::CMD_LOAD;
  logic [1:0]                    word_index_i = '0;
  logic [WB-1:0]                 seed_cells_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [1:0]                    word_index_res_o;
  logic [WB-1:0]                 row_cells_o;
  logic                          last_o;
  logic                          settled_o;

  // predictor state
  logic [ROW_CELLS-1:0]          life_pending = '0;
  logic [HIST_DEPTH-1:0]         life_hist [ROW_CELLS];
  logic [oda_pkg::CFG_W-1:0]     life_width = oda_pkg::CELLS_IN_USE_RESET;

  life_cmd_t  cmd_q[$];
  life_word_t gen_words_q[$];

  int  fail_cnt = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  quiet_cycles = 0;
  bit  steady_phase = 1'b0;

  one_d_life_automaton #(
    .CELLS        (ROW_CELLS),
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .word_index_i    (word_index_i),
    .seed_cells_i    (seed_cells_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_index_res_o(word_index_res_o),
    .row_cells_o     (row_cells_o),
    .last_o          (last_o),
    .settled_o       (settled_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    foreach (life_hist[i]) life_hist[i] = '0;
  end

  function automatic void load_seed_word(input logic [1:0] idx, input logic [WB-1:0] seed);
    life_pending[int'(idx)*WB +: WB] = seed;
    foreach (life_hist[i]) life_hist[i] = '0;
  endfunction

  // one generation: pending becomes current, next row goes out word by word
  function automatic void advance_generation();
    int                   active;
    int                   nwords;
    int                   total;
    logic [ROW_CELLS-1:0] cur;
    logic [ROW_CELLS-1:0] nxt;
    logic                 alive;
    bit                   calm;
    life_word_t           w;
    active = (life_width > ROW_CELLS) ? ROW_CELLS : int'(life_width);
    cur = '0;
    for (int i = 0; i < ROW_CELLS; i++) begin
      if (i < active) cur[i] = life_pending[i];
      life_hist[i] = {life_hist[i][HIST_DEPTH-2:0], cur[i]};
    end
    nxt = '0;
    calm = 1'b1;
    for (int i = 0; i < active; i++) begin
      total = 0;
      if (i >= 2) total += int'(cur[i-2]);
      if (i >= 1) total += int'(cur[i-1]);
      if (i + 1 < active) total += int'(cur[i+1]);
      if (i + 2 < active) total += int'(cur[i+2]);
      if (cur[i]) alive = (total == 2 || total == 4);
      else alive = (total == 2 || total == 3);
      if (alive) begin
        nxt[i] = 1'b1;
        if (life_hist[i] == '0) calm = 1'b0;
      end else if (life_hist[i] == {HIST_DEPTH{1'b1}}) begin
        calm = 1'b0;
      end
    end
    life_pending = nxt;
    nwords = (active + WB - 1) / WB;
    if (nwords == 0) begin
      w = '{word_index: 2'd0, cells: '0, last: 1'b1, settled: 1'b1};
      gen_words_q.push_back(w);
    end
    for (int k = 0; k < nwords; k++) begin
      w.word_index = 2'(k);
      w.cells = nxt[k*WB +: WB];
      w.last = (k + 1 == nwords);
      w.settled = (k + 1 == nwords) && calm;
      gen_words_q.push_back(w);
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [WB-1:0] seed_pattern();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1: return '1;
      2: return '0;
      3: return {32{2'b01}} << $urandom_range(0, 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin : cmd_driver
    life_cmd_t beat;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == oda_pkg::CMD_LOAD) load_seed_word(word_index_i, seed_cells_i);
        else advance_generation();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].drain_first || gen_words_q.size() == 0)) begin
          beat = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= beat.cmd;
          word_index_i <= beat.idx;
          seed_cells_i <= beat.seed;
          if (steady_phase || $urandom_range(0, 99) < 60) send_gap <= 0;
          else send_gap <= pick_idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
        out_stall_i <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        holds_done <= holds_done + 1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!steady_phase && $urandom_range(0, 99) < 25) begin
        out_stall_i <= 1'b1;
        stall_left <= pick_idle_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : word_checker
    life_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gen_words_q.size() == 0) begin
        $error("unexpected output beat: word_index_res %0d row_cells %h",
               word_index_res_o, row_cells_o);
        fail_cnt++;
      end else begin
        want = gen_words_q.pop_front();
        if (word_index_res_o !== want.word_index) begin
          $error("word_index_res: expected %0d, got %0d", want.word_index, word_index_res_o);
          fail_cnt++;
        end
        if (row_cells_o !== want.cells) begin
          $error("row_cells: expected %h, got %h", want.cells, row_cells_o);
          fail_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_cnt++;
        end
        if (settled_o !== want.settled) begin
          $error("settled: expected %0b, got %0b", want.settled, settled_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $error("no handshake for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_cmd(input logic cmd, input logic [1:0] idx, input logic [WB-1:0] seed,
                           input bit drain);
    life_cmd_t c;
    c = '{cmd: cmd, idx: idx, seed: seed, drain_first: drain};
    cmd_q.push_back(c);
  endtask

  task automatic queue_step();
    queue_cmd(oda_pkg::CMD_STEP, 2'($urandom_range(0, 3)), {$urandom, $urandom}, 1'b0);
  endtask

  task automatic wait_idle();
    while (!(cmd_q.size() == 0 && !in_valid_i && gen_words_q.size() == 0))
      @(posedge clk_i);
    // a load gives no beat, let it finish
    repeat (8) @(posedge clk_i);
  endtask

  // write then read back cells_in_use, only while idle
  task automatic write_cells_in_use(input int unsigned value, input logic [22:0] junk);
    wait_idle();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CELLS_IN_USE_ADDR;
    pwdata <= {junk, value[oda_pkg::CFG_W-1:0]};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    life_width = value[oda_pkg::CFG_W-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[oda_pkg::CFG_W-1:0] !== life_width) begin
      $error("cells_in_use: expected %0d, got %0d", life_width, prdata[oda_pkg::CFG_W-1:0]);
      fail_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // well-formed runs (loads then steps) with some stray commands
  task automatic queue_random_phase(input int n_items, input bit mid_drain);
    int count;
    int nloads;
    int nsteps;
    bit drained;
    bit drain;
    count = 0;
    drained = 1'b0;
    while (count < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        nloads = $urandom_range(1, 4);
        nsteps = $urandom_range(2, 6);
        for (int j = 0; j < nloads; j++) begin
          drain = ($urandom_range(0, 29) == 0);
          if (j == 0 && mid_drain && !drained && count >= n_items / 2) begin
            drain = 1'b1;
            drained = 1'b1;
          end
          queue_cmd(oda_pkg::CMD_LOAD, (nloads == 4) ? 2'(j) : 2'($urandom_range(0, 3)),
                    seed_pattern(), drain);
        end
        for (int j = 0; j < nsteps; j++) queue_step();
        count += nloads + nsteps;
      end else begin
        queue_cmd(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), seed_pattern(), 1'b0);
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned width;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // empty row, then all four words with edge patterns
    queue_step();
    queue_cmd(oda_pkg::CMD_LOAD, 2'd0, '1, 1'b0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd1, {32{2'b01}}, 1'b0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd2, 64'h1, 1'b0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd3, 64'h8000_0000_0000_0000, 1'b0);
    queue_step();
    queue_step();
    // load clears history but keeps the other words
    queue_cmd(oda_pkg::CMD_LOAD, 2'd3, '1, 1'b0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd0, '0, 1'b0);
    queue_step();
    queue_step();
    queue_step();

    // zero width
    write_cells_in_use(0, '0);
    queue_step();
    queue_cmd(oda_pkg::CMD_LOAD, 2'd0, '1, 1'b0);
    queue_step();
    // width below five
    write_cells_in_use(3, '0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd0, 64'h7, 1'b0);
    queue_step();
    queue_step();
    write_cells_in_use(5, '0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd0, 64'h1b, 1'b0);
    queue_step();
    // width above the row, with junk in the unused data bits
    write_cells_in_use(511, '1);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd3, '1, 1'b0);
    queue_step();
    write_cells_in_use(65, '0);
    queue_cmd(oda_pkg::CMD_LOAD, 2'd1, '1, 1'b0);
    queue_step();

    for (int p = 0; p < 7; p++) begin
      case (p)
        1: width = $urandom_range(5, 256);
        2: width = 5;
        4: width = $urandom_range(65, 255);
        5: width = 300;
        6: width = 64;
        default: width = 256;
      endcase
      write_cells_in_use(width, 23'($urandom));
      steady_phase = (p == 1);
      queue_random_phase(16, p == 2);
      // receiver holds off while the sender keeps offering
      if (p == 3) hold_requests++;
    end

    wait_idle();
    if (fail_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
